FILE: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

   // Queue capacity and the widths that follow from it.
   localparam int DEPTH   = 16;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int COUNT_W = 5;

   // Request kinds.
   typedef enum logic {
      REQ_ENQ = 1'b0,
      REQ_DEQ = 1'b1
   } spq_kind_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_ENQ   = 2'd0,
      ST_FULL  = 2'd1,
      ST_DEQ   = 2'd2,
      ST_EMPTY = 2'd3
   } spq_status_type;

   // One queue entry as held in the entry memory.
   typedef struct packed {
      logic [15:0] proc_id;
      logic [15:0] burst_ms;
      logic [2:0]  proc_state;
   } spq_entry_type;

   localparam int ENTRY_W = $bits(spq_entry_type);

   // Request handed from the port logic to the sequencer.
   typedef struct packed {
      spq_kind_type  kind;
      spq_entry_type entry;
   } spq_req_type;

   // Result handed from the sequencer to the output register.
   typedef struct packed {
      spq_status_type       status;
      spq_entry_type        entry;
      logic [COUNT_W-1:0]   count;
   } spq_rsp_type;

endpackage

FILE: rtl/spq_ram.sv
// Generic single-write, single-read memory with a registered read port.
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/spq_core.sv
// Sequencer that walks the sorted entry memory with one shared key comparator.
module spq_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  spq_pkg::spq_req_type req,
   output logic                idle,
   output logic                res_valid,
   input  logic                res_take,
   output spq_pkg::spq_rsp_type res
);

   import spq_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      ENQ_CMP,
      ENQ_PUT,
      DEQ_HEAD,
      DEQ_SH,
      DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   spq_entry_type       item_ff, item_in;
   spq_rsp_type         res_ff, res_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   spq_entry_type       wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0]  rd_bits;
   spq_entry_type       rd_data;
   logic                key_greater;
   logic [CNT_W:0]      next2;
   logic [CNT_W+COUNT_W-1:0] held_wide;

   // Entry memory, with one entry read and one entry written per cycle.
   spq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_data = spq_entry_type'(rd_bits);

   // The one key comparator shared by every insertion step.
   assign key_greater = rd_data.burst_ms > item_ff.burst_ms;

   // Index two places beyond the current shift position.
   assign next2 = (CNT_W + 1)'(pos_ff) + (CNT_W + 1)'(2);

   // Count reported with the result is the low bits of the new fill level.
   assign held_wide = {{COUNT_W{1'b0}}, held_in};

   // Next-state and datapath control.
   always_comb begin
      state_in = state_ff;
      held_in  = held_ff;
      pos_in   = pos_ff;
      item_in  = item_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = pos_ff;
      wr_data  = item_ff;
      rd_addr  = '0;

      case (state_ff)
         IDLE: begin
            if (start) begin
               item_in      = req.entry;
               res_in.entry = '0;
               if (req.kind == REQ_DEQ) begin
                  if (held_ff == '0) begin
                     res_in.status = ST_EMPTY;
                     state_in      = DONE;
                  end else begin
                     rd_addr  = '0;
                     state_in = DEQ_HEAD;
                  end
               end else if (held_ff == CNT_W'(DEPTH)) begin
                  res_in.status = ST_FULL;
                  state_in      = DONE;
               end else if (held_ff == '0) begin
                  wr_en         = 1'b1;
                  wr_addr       = '0;
                  wr_data       = req.entry;
                  held_in       = CNT_W'(1);
                  res_in.status = ST_ENQ;
                  state_in      = DONE;
               end else begin
                  pos_in   = held_ff[ADDR_W-1:0];
                  rd_addr  = held_ff[ADDR_W-1:0] - ADDR_W'(1);
                  state_in = ENQ_CMP;
               end
            end
         end

         // Move larger keys up one slot until the insertion point is found.
         ENQ_CMP: begin
            wr_en = 1'b1;
            if (key_greater) begin
               wr_data = rd_data;
               pos_in  = pos_ff - ADDR_W'(1);
               if (pos_ff == ADDR_W'(1)) begin
                  state_in = ENQ_PUT;
               end else begin
                  rd_addr = pos_ff - ADDR_W'(2);
               end
            end else begin
               wr_data       = item_ff;
               held_in       = held_ff + CNT_W'(1);
               res_in.status = ST_ENQ;
               state_in      = DONE;
            end
         end

         // New entry goes to the head.
         ENQ_PUT: begin
            wr_en         = 1'b1;
            wr_data       = item_ff;
            held_in       = held_ff + CNT_W'(1);
            res_in.status = ST_ENQ;
            state_in      = DONE;
         end

         // Capture the head entry, then start closing the gap.
         DEQ_HEAD: begin
            res_in.entry  = rd_data;
            res_in.status = ST_DEQ;
            if (held_ff == CNT_W'(1)) begin
               held_in  = '0;
               state_in = DONE;
            end else begin
               rd_addr  = ADDR_W'(1);
               pos_in   = '0;
               state_in = DEQ_SH;
            end
         end

         // Copy each following entry one slot toward the head.
         DEQ_SH: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            if (next2 < {1'b0, held_ff}) begin
               rd_addr = next2[ADDR_W-1:0];
               pos_in  = pos_ff + ADDR_W'(1);
            end else begin
               held_in  = held_ff - CNT_W'(1);
               state_in = DONE;
            end
         end

         DONE: begin
            if (res_take) begin
               state_in = IDLE;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase

      if (state_ff != DONE && state_in == DONE) begin
         res_in.count = held_wide[COUNT_W-1:0];
      end
   end

   // State, fill level and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
      pos_ff  <= pos_in;
      item_ff <= item_in;
      res_ff  <= res_in;
   end

   assign idle      = (state_ff == IDLE);
   assign res_valid = (state_ff == DONE);
   assign res       = res_ff;

endmodule

FILE: rtl/sorted_priority_queue_unit.sv
// Top level of the shortest-job-first queue: stream ports and result register.
//
// A shortest-job-first ready queue of DEPTH entries kept sorted by burst time
// in a small single-port-read memory. An enqueue places the new entry behind
// every entry with an equal or smaller burst time; a dequeue returns the head.
// Each request yields one result with the new fill count. Requests are taken
// one at a time. An enqueue moves every entry with a larger burst time up one
// slot, from the tail toward the head, and then writes the new entry into the
// gap. A dequeue returns the head and then copies each following entry one
// slot toward the head to close the gap. A rejected (full) or empty request
// is answered without touching the memory. Entries move through the single
// read and write port of the entry memory, one entry move per cycle. The
// result then sits in an output register, and the next request is taken as
// soon as the sequencer has handed its result over.
module sorted_priority_queue_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // proc_id[15:0], burst_ms[31:16], proc_state[34:32]
   input  logic        req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // out_proc_id[15:0], out_burst_ms[31:16],
                                   // out_proc_state[34:32], count[39:35]
   output logic [1:0]  rsp_tuser   // status
);

   import spq_pkg::*;

   logic        core_idle;
   logic        core_valid;
   logic        core_take;
   logic        start;
   spq_req_type core_req;
   spq_rsp_type core_res;

   logic        rsp_valid_ff, rsp_valid_in;
   spq_rsp_type rsp_ff, rsp_in;

   // Unpack the incoming request.
   assign core_req.kind             = spq_kind_type'(req_tuser);
   assign core_req.entry.proc_id    = req_tdata[15:0];
   assign core_req.entry.burst_ms   = req_tdata[31:16];
   assign core_req.entry.proc_state = req_tdata[34:32];

   assign req_tready = core_idle;
   assign start      = req_tvalid && core_idle;

   spq_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (core_req),
      .idle      (core_idle),
      .res_valid (core_valid),
      .res_take  (core_take),
      .res       (core_res)
   );

   // The output register takes a result whenever it is empty or being drained.
   assign core_take = core_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (core_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // Pack the result onto the stream.
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tuser        = rsp_ff.status;
   assign rsp_tdata[15:0]  = rsp_ff.entry.proc_id;
   assign rsp_tdata[31:16] = rsp_ff.entry.burst_ms;
   assign rsp_tdata[34:32] = rsp_ff.entry.proc_state;
   assign rsp_tdata[39:35] = rsp_ff.count;

endmodule
